// ===== hw/rtl/ems_pkg.sv =====
// Shared types and constants for the encoded minimum stack.
`default_nettype none
package ems_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned WORD_W = 34;
    localparam int unsigned STAT_W = 2;

    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_POP  = 1'b1;

    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_POP_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] STAT_PUSH_FULL = 2'd2;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } ctrl_state_t;

    typedef struct packed {
        logic exec;
        logic load_out;
    } ctl_cmd_t;

endpackage
`default_nettype wire

// ===== hw/rtl/encoded_min_stack.sv =====
// Top level of the encoded minimum stack: controller, datapath and port packing.
// Each transaction is accepted in ST_IDLE; its result is registered from ST_EMIT once no
// earlier result still waits on the master side.
// A new transaction waits until the last result is registered; a pop reads the new top from the
// stack RAM (registered read port) before the result is formed.
// s_tready may be high while a result still waits on the master side.
// Reset (aresetn, synchronous, active low): stack empty, minimum zero, no result.
`default_nettype none
module encoded_min_stack #(
    parameter int unsigned DEPTH = 256
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] value
    input  wire logic [0:0]  s_tuser,   // [0] kind
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata    // [31:0] top_value, [63:32] min_value,
                                        // [64] is_empty, [66:65] status, rest zero
);
    import ems_pkg::*;

    ctl_cmd_t                 cmd;
    logic signed [DATA_W-1:0] top_value, min_value;
    logic                     is_empty;
    logic [STAT_W-1:0]        status;

    ems_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    ems_dpath #(.DEPTH(DEPTH)) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .kind      (s_tuser[0]),
        .value     (s_tdata),
        .top_value (top_value),
        .min_value (min_value),
        .is_empty  (is_empty),
        .status    (status)
    );

    assign m_tdata = {5'b0, status, is_empty, min_value, top_value};

endmodule
`default_nettype wire

// ===== hw/rtl/ems_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ems_ram #(
    parameter int unsigned WIDTH = 34,
    parameter int unsigned DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ===== hw/rtl/ems_ctrl.sv =====
// Controller state machine: accepts transactions and sequences result output.
`default_nettype none
module ems_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output ems_pkg::ctl_cmd_t  cmd
);
    import ems_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic        m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready     = 1'b0;
        cmd.exec     = 1'b0;
        cmd.load_out = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.exec = s_tvalid;
            end
            ST_EMIT: begin
                cmd.load_out = !m_valid_reg || m_tready;
            end
            default: ;
        endcase
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    assign m_tvalid = m_valid_reg;

`ifndef SYNTHESIS
    a_exec_to_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.exec |=> state_reg == ST_EMIT)
        else $error("accepted transaction did not enter emit");
    a_load_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |=> m_valid_reg)
        else $error("result load did not raise valid");
    a_emit_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT && !cmd.load_out) |=> state_reg == ST_EMIT)
        else $error("left emit without loading result");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/ems_dpath.sv =====
// Datapath: fill count, minimum, cached top word, stack RAM and result register.
`default_nettype none
module ems_dpath #(
    parameter int unsigned DEPTH = 256
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire ems_pkg::ctl_cmd_t                 cmd,
    input  wire logic                              kind,
    input  wire logic signed [ems_pkg::DATA_W-1:0] value,
    output logic signed      [ems_pkg::DATA_W-1:0] top_value,
    output logic signed      [ems_pkg::DATA_W-1:0] min_value,
    output logic                                   is_empty,
    output logic             [ems_pkg::STAT_W-1:0] status
);
    import ems_pkg::*;

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic [CW-1:0]              count_reg, count_next;
    logic signed [DATA_W-1:0]   min_reg, min_next;
    logic signed [WORD_W-1:0]   top_reg, top_next;
    logic                       pop_pend_reg, pop_pend_next;
    logic [STAT_W-1:0]          stat_reg, stat_next;
    logic [AW-1:0]              raddr_reg, raddr_next;

    logic signed [DATA_W-1:0]   out_top_reg, out_top_next;
    logic signed [DATA_W-1:0]   out_min_reg, out_min_next;
    logic                       out_empty_reg, out_empty_next;
    logic [STAT_W-1:0]          out_stat_reg, out_stat_next;

    logic signed [WORD_W-1:0]   x34, min34, enc_word, restore, word_cur, rdata;
    logic                       we;
    logic [WORD_W-1:0]          wdata;

    assign x34      = WORD_W'(value);
    assign min34    = WORD_W'(min_reg);
    assign enc_word = {x34[WORD_W-2:0], 1'b0} - min34;
    assign restore  = {min34[WORD_W-2:0], 1'b0} - top_reg;
    assign word_cur = pop_pend_reg ? rdata : top_reg;

    ems_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_ram (
        .aclk  (aclk),
        .we    (we),
        .waddr (count_reg[AW-1:0]),
        .wdata (wdata),
        .raddr (raddr_next),
        .rdata (rdata)
    );

    always_comb begin
        count_next    = count_reg;
        min_next      = min_reg;
        top_next      = top_reg;
        pop_pend_next = pop_pend_reg;
        stat_next     = stat_reg;
        raddr_next    = raddr_reg;
        we            = 1'b0;
        wdata         = x34;
        if (cmd.exec) begin
            pop_pend_next = 1'b0;
            stat_next     = STAT_OK;
            if (kind == KIND_POP) begin
                if (count_reg == '0) begin
                    stat_next = STAT_POP_EMPTY;
                end else begin
                    if (top_reg < min34) begin
                        min_next = restore[DATA_W-1:0];
                    end
                    count_next    = count_reg - CW'(1);
                    pop_pend_next = 1'b1;
                    raddr_next    = (count_reg >= CW'(2)) ?
                                    AW'(count_reg - CW'(2)) : '0;
                end
            end else begin
                if (count_reg == CW'(DEPTH)) begin
                    stat_next = STAT_PUSH_FULL;
                end else begin
                    we = 1'b1;
                    if (count_reg == '0) begin
                        wdata    = x34;
                        min_next = value;
                    end else if (value < min_reg) begin
                        wdata    = enc_word;
                        min_next = value;
                    end else begin
                        wdata = x34;
                    end
                    top_next   = wdata;
                    count_next = count_reg + CW'(1);
                end
            end
        end
        if (cmd.load_out) begin
            top_next      = word_cur;
            pop_pend_next = 1'b0;
        end
    end

    always_comb begin
        out_top_next   = out_top_reg;
        out_min_next   = out_min_reg;
        out_empty_next = out_empty_reg;
        out_stat_next  = out_stat_reg;
        if (cmd.load_out) begin
            out_stat_next = stat_reg;
            if (count_reg == '0) begin
                out_top_next   = '1;
                out_min_next   = '1;
                out_empty_next = 1'b1;
            end else begin
                out_top_next   = (word_cur < min34) ? min_reg : word_cur[DATA_W-1:0];
                out_min_next   = min_reg;
                out_empty_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            min_reg      <= '0;
            pop_pend_reg <= 1'b0;
        end else begin
            count_reg    <= count_next;
            min_reg      <= min_next;
            pop_pend_reg <= pop_pend_next;
        end
        top_reg       <= top_next;
        stat_reg      <= stat_next;
        raddr_reg     <= raddr_next;
        out_top_reg   <= out_top_next;
        out_min_reg   <= out_min_next;
        out_empty_reg <= out_empty_next;
        out_stat_reg  <= out_stat_next;
    end

    assign top_value = out_top_reg;
    assign min_value = out_min_reg;
    assign is_empty  = out_empty_reg;
    assign status    = out_stat_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("fill count beyond depth");
    a_empty_reads_ones: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.load_out && count_reg == '0) |=> (out_empty_reg && out_top_reg == '1
            && out_min_reg == '1))
        else $error("empty result not reported as all ones");
    a_full_push_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.exec && kind == KIND_PUSH && count_reg == CW'(DEPTH))
            |=> count_reg == $past(count_reg) && stat_reg == STAT_PUSH_FULL)
        else $error("push on full stack changed the fill count");
`endif

endmodule
`default_nettype wire
